### rtl/core/i2c_master_register_access_assert.svh
// Assertion macros used by the I2C master sequencer.
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 32;

   // Word index of the only configuration register.
   localparam logic RegDeviceAddress = 1'b0;

   localparam logic [6:0] DevAddrReset = 7'd64;
   localparam logic [1:0] MaxBytes     = 2'd2;
   localparam logic       ReadBit      = 1'b1;
   localparam logic       WriteBit     = 1'b0;

   typedef struct packed {
      logic        kind;
      logic        is_read;
      logic [7:0]  reg_address;
      logic [15:0] write_data;
      logic [1:0]  byte_count;
      logic        sda_in;
   } req_type;

   typedef struct packed {
      logic        scl_level;
      logic        sda_level;
      logic        sda_enable;
      logic        busy_res;
      logic        done_res;
      logic [15:0] read_data;
      logic        nack_seen;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/core/i2cm_csr.sv
`default_nettype none

module i2cm_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [i2cm_pkg::CsrAddrWidth-1:0]  paddr,
   input  wire logic [i2cm_pkg::CsrDataWidth-1:0]  pwdata,
   output logic      [i2cm_pkg::CsrDataWidth-1:0]  prdata,
   output logic                                    pready,
   output logic      [6:0]                         device_address
);

   logic [6:0] dev_addr_ff;
   logic [6:0] dev_addr_in;
   logic       reg_hit;

   assign reg_hit = (paddr[i2cm_pkg::CsrAddrWidth-1:2] == i2cm_pkg::RegDeviceAddress);

   always_comb begin
      dev_addr_in = dev_addr_ff;
      if (psel && penable && pwrite && reg_hit) begin
         dev_addr_in = pwdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= i2cm_pkg::DevAddrReset;
      end else begin
         dev_addr_ff <= dev_addr_in;
      end
   end

   assign pready         = 1'b1;
   assign prdata         = reg_hit ? {{(i2cm_pkg::CsrDataWidth-7){1'b0}}, dev_addr_ff}
                                   : '0;
   assign device_address = dev_addr_ff;

endmodule

`default_nettype wire

### rtl/core/i2cm_seq.sv
`default_nettype none

module i2cm_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire i2cm_pkg::req_type req,
   input  wire logic [6:0]        device_address,
   output i2cm_pkg::rsp_type      rsp
);

`include "i2c_master_register_access_assert.svh"

   typedef enum logic [4:0] {
      PH_IDLE, PH_START, PH_ADDR_W, PH_REG, PH_DATA_TX,
      PH_RESTART, PH_ADDR_R, PH_DATA_RX, PH_STOP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bit_ff, bit_in;
   logic [1:0]  sub_ff, sub_in;
   logic [7:0]  shift_ff, shift_in;
   logic [1:0]  left_ff, left_in;
   logic [15:0] hold_ff, hold_in;
   logic        dir_ff, dir_in;
   logic        nack_ff, nack_in;
   logic [7:0]  reg_ff, reg_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        en_ff, en_in;
   logic        done;
   logic [1:0]  cnt;
   logic [1:0]  left_dec;

   // Byte count: zero counts as one, above the limit saturates.
   assign cnt = (req.byte_count == 2'd0)     ? 2'd1 :
                (req.byte_count > i2cm_pkg::MaxBytes) ? i2cm_pkg::MaxBytes :
                req.byte_count;
   assign left_dec = (left_ff != 2'd0) ? left_ff - 2'd1 : 2'd0;

   always_comb begin
      phase_in = phase_ff;
      bit_in   = bit_ff;
      sub_in   = sub_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      hold_in  = hold_ff;
      dir_in   = dir_ff;
      nack_in  = nack_ff;
      reg_in   = reg_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      en_in    = en_ff;
      done     = 1'b0;
      if (req.kind) begin
         // A request while a transaction runs is dropped.
         if (phase_ff == PH_IDLE) begin
            dir_in  = req.is_read;
            reg_in  = req.reg_address;
            left_in = cnt;
            if (req.is_read) begin
               hold_in = 16'd0;
            end else if (cnt == 2'd1) begin
               hold_in = {req.write_data[7:0], 8'd0};
            end else begin
               hold_in = req.write_data;
            end
            nack_in  = 1'b0;
            bit_in   = 4'd0;
            shift_in = 8'd0;
            sub_in   = 2'd0;
            phase_in = PH_START;
         end
      end else begin
         case (phase_ff)
            PH_START, PH_RESTART: begin
               case (sub_ff)
                  2'd0: begin
                     en_in  = 1'b1;
                     sda_in = 1'b1;
                     sub_in = 2'd1;
                  end
                  2'd1: begin
                     scl_in = 1'b1;
                     sub_in = 2'd2;
                  end
                  2'd2: begin
                     sda_in = 1'b0;
                     sub_in = 2'd3;
                  end
                  default: begin
                     scl_in = 1'b0;
                     bit_in = 4'd0;
                     sub_in = 2'd0;
                     if (phase_ff == PH_START) begin
                        phase_in = PH_ADDR_W;
                        shift_in = {device_address, i2cm_pkg::WriteBit};
                     end else begin
                        phase_in = PH_ADDR_R;
                        shift_in = {device_address, i2cm_pkg::ReadBit};
                     end
                  end
               endcase
            end
            PH_ADDR_W, PH_REG, PH_DATA_TX, PH_ADDR_R: begin
               if (bit_ff < 4'd8) begin
                  case (sub_ff)
                     2'd0: begin
                        en_in  = 1'b1;
                        sda_in = shift_ff[7];
                        sub_in = 2'd1;
                     end
                     2'd1: begin
                        scl_in = 1'b1;
                        sub_in = 2'd2;
                     end
                     default: begin
                        scl_in   = 1'b0;
                        shift_in = {shift_ff[6:0], 1'b0};
                        bit_in   = bit_ff + 4'd1;
                        sub_in   = 2'd0;
                     end
                  endcase
               end else begin
                  // Ack slot driven by the slave.
                  case (sub_ff)
                     2'd0: begin
                        en_in  = 1'b0;
                        sda_in = 1'b1;
                        sub_in = 2'd1;
                     end
                     2'd1: begin
                        scl_in = 1'b1;
                        if (req.sda_in) begin
                           nack_in = 1'b1;
                        end
                        sub_in = 2'd2;
                     end
                     default: begin
                        scl_in = 1'b0;
                        sub_in = 2'd0;
                        bit_in = 4'd0;
                        case (phase_ff)
                           PH_ADDR_W: begin
                              phase_in = PH_REG;
                              shift_in = reg_ff;
                           end
                           PH_REG: begin
                              if (dir_ff) begin
                                 phase_in = PH_RESTART;
                                 bit_in   = bit_ff;
                              end else begin
                                 phase_in = PH_DATA_TX;
                                 shift_in = hold_ff[15:8];
                                 hold_in  = {hold_ff[7:0], 8'd0};
                              end
                           end
                           PH_DATA_TX: begin
                              left_in = left_dec;
                              if (left_dec != 2'd0) begin
                                 shift_in = hold_ff[15:8];
                                 hold_in  = {hold_ff[7:0], 8'd0};
                              end else begin
                                 phase_in = PH_STOP;
                                 bit_in   = bit_ff;
                              end
                           end
                           default: begin
                              phase_in = PH_DATA_RX;
                              shift_in = 8'd0;
                           end
                        endcase
                     end
                  endcase
               end
            end
            PH_DATA_RX: begin
               if (bit_ff < 4'd8) begin
                  case (sub_ff)
                     2'd0: begin
                        en_in  = 1'b0;
                        sda_in = 1'b1;
                        sub_in = 2'd1;
                     end
                     2'd1: begin
                        scl_in   = 1'b1;
                        shift_in = {shift_ff[6:0], req.sda_in};
                        sub_in   = 2'd2;
                     end
                     default: begin
                        scl_in = 1'b0;
                        bit_in = bit_ff + 4'd1;
                        sub_in = 2'd0;
                     end
                  endcase
               end else begin
                  // Master ack: NACK after the last byte.
                  case (sub_ff)
                     2'd0: begin
                        en_in  = 1'b1;
                        sda_in = (left_ff <= 2'd1);
                        sub_in = 2'd1;
                     end
                     2'd1: begin
                        scl_in = 1'b1;
                        sub_in = 2'd2;
                     end
                     default: begin
                        scl_in  = 1'b0;
                        hold_in = {hold_ff[7:0], shift_ff};
                        left_in = left_dec;
                        sub_in  = 2'd0;
                        if (left_dec != 2'd0) begin
                           shift_in = 8'd0;
                           bit_in   = 4'd0;
                        end else begin
                           phase_in = PH_STOP;
                        end
                     end
                  endcase
               end
            end
            PH_STOP: begin
               case (sub_ff)
                  2'd0: begin
                     en_in  = 1'b1;
                     sda_in = 1'b0;
                     sub_in = 2'd1;
                  end
                  2'd1: begin
                     scl_in = 1'b1;
                     sub_in = 2'd2;
                  end
                  default: begin
                     sda_in   = 1'b1;
                     sub_in   = 2'd0;
                     phase_in = PH_IDLE;
                     done     = 1'b1;
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff   <= 4'd0;
         sub_ff   <= 2'd0;
         shift_ff <= 8'd0;
         left_ff  <= 2'd0;
         hold_ff  <= 16'd0;
         dir_ff   <= 1'b0;
         nack_ff  <= 1'b0;
         reg_ff   <= 8'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         en_ff    <= 1'b1;
      end else if (step_en) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         sub_ff   <= sub_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
         hold_ff  <= hold_in;
         dir_ff   <= dir_in;
         nack_ff  <= nack_in;
         reg_ff   <= reg_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         en_ff    <= en_in;
      end
   end

   // The result describes the state after this beat's step.
   always_comb begin
      rsp.scl_level  = scl_in;
      rsp.sda_level  = sda_in;
      rsp.sda_enable = en_in;
      rsp.busy_res   = (phase_in != PH_IDLE);
      rsp.done_res   = done;
      rsp.read_data  = dir_in ? hold_in : 16'd0;
      rsp.nack_seen  = nack_in;
   end

   `I2CM_ASSERT_SAME(a_idle_lines_high, clock, reset, (phase_ff == PH_IDLE), (scl_ff && sda_ff && en_ff), "bus lines not released high while idle")
   `I2CM_ASSERT_SAME(a_bit_count_range, clock, reset, 1'b1, (bit_ff <= 4'd8), "bit count beyond one byte")
   `I2CM_ASSERT_SAME(a_sub_step_range, clock, reset, (phase_ff != PH_START && phase_ff != PH_RESTART), (sub_ff != 2'd3), "fourth sub-step outside a start condition")
   `I2CM_ASSERT_NEXT(a_done_goes_idle, clock, reset, (step_en && done), (phase_ff == PH_IDLE && !scl_ff == 1'b0), "sequencer not idle after stop")

endmodule

`default_nettype wire

### rtl/core/i2c_master_register_access.sv
`default_nettype none

// I2C register-access master. Each request beat (kind = 1) latches one register write or read
// transaction if the sequencer is idle; each tick beat (kind = 0) makes one SCL or SDA change, and
// every beat accepted on the req_ channel returns exactly one rsp_ beat with the bus levels, busy,
// done, read data and the slave NACK flag after that step. One beat is accepted every clock cycle
// unless rsp_stall holds the result register: a beat is captured in an input register, and the
// sequencer step runs between that register and the result register. device_address sits at byte
// address 0 of the APB port and should only be written while no transaction is running.

module i2c_master_register_access (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_kind,
   input  wire logic                               req_is_read,
   input  wire logic [7:0]                         req_reg_address,
   input  wire logic [15:0]                        req_write_data,
   input  wire logic [1:0]                         req_byte_count,
   input  wire logic                               req_sda_in,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_scl_level,
   output logic                                    rsp_sda_level,
   output logic                                    rsp_sda_enable,
   output logic                                    rsp_busy_res,
   output logic                                    rsp_done_res,
   output logic      [15:0]                        rsp_read_data,
   output logic                                    rsp_nack_seen,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [i2cm_pkg::CsrAddrWidth-1:0]  paddr,
   input  wire logic [i2cm_pkg::CsrDataWidth-1:0]  pwdata,
   output logic      [i2cm_pkg::CsrDataWidth-1:0]  prdata,
   output logic                                    pready
);

   i2cm_pkg::req_type in_ff, in_in;
   logic              in_valid_ff, in_valid_in;
   i2cm_pkg::rsp_type out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   i2cm_pkg::rsp_type step_rsp;
   logic [6:0]        device_address;
   logic              out_free;
   logic              advance;
   logic              accept_in;

   i2cm_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .device_address (device_address)
   );

   i2cm_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .step_en        (advance),
      .req            (in_ff),
      .device_address (device_address),
      .rsp            (step_rsp)
   );

   // The held beat steps the sequencer once the result register can take its result.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept_in = req_valid && !req_stall;

   always_comb begin
      in_in.kind        = req_kind;
      in_in.is_read     = req_is_read;
      in_in.reg_address = req_reg_address;
      in_in.write_data  = req_write_data;
      in_in.byte_count  = req_byte_count;
      in_in.sda_in      = req_sda_in;
      in_valid_in       = accept_in || (in_valid_ff && !advance);
      out_in            = step_rsp;
      out_valid_in      = advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         in_ff <= in_in;
      end
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_scl_level  = out_ff.scl_level;
   assign rsp_sda_level  = out_ff.sda_level;
   assign rsp_sda_enable = out_ff.sda_enable;
   assign rsp_busy_res   = out_ff.busy_res;
   assign rsp_done_res   = out_ff.done_res;
   assign rsp_read_data  = out_ff.read_data;
   assign rsp_nack_seen  = out_ff.nack_seen;

endmodule

`default_nettype wire
